>>> rtl/core/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg - shared types and constants for the link layer decapsulation parser
// Verdict codes, link kinds, register indexes and the result record.
// ----------------------------------------------------------------------------
package lld_pkg;

    // Label stack depth limit (1 to 16; the label counter is 4 bits wide)
    localparam int MAX_LABELS = 8;

    // Widths of the fields of one transfer
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 7;
    localparam int HDR_W   = 7;
    localparam int PROTO_W = 32;
    localparam int KIND_W  = 3;
    localparam int IDX_W   = 2;
    localparam int LBL_W   = 4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LINK_KIND   = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEFAULT_HDR = 2'd1;
    localparam logic [IDX_W-1:0] REG_IPV6_FAMILY = 2'd2;

    // Reset values of the configuration registers
    localparam logic [KIND_W-1:0] RST_LINK_KIND   = 3'd1;
    localparam logic [HDR_W-1:0]  RST_DEFAULT_HDR = 7'd14;
    localparam logic [BYTE_W-1:0] RST_IPV6_FAMILY = 8'd10;

    // Link kinds
    localparam logic [KIND_W-1:0] LK_LOOPBACK = 3'd0;
    localparam logic [KIND_W-1:0] LK_ETHERNET = 3'd1;
    localparam logic [KIND_W-1:0] LK_FDDI     = 3'd2;
    localparam logic [KIND_W-1:0] LK_COOKED   = 3'd3;
    localparam logic [KIND_W-1:0] LK_PPP      = 3'd4;
    localparam logic [KIND_W-1:0] LK_RAW      = 3'd5;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_LOOP  = 3'd1,
        ST_PPPOE = 3'd2,
        ST_PPP   = 3'd3,
        ST_DEEP  = 3'd4,
        ST_TRUNC = 3'd5
    } t_status;

    // One result item
    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   offset;
        logic [HDR_W-1:0]   rep_hdr;
        logic [PROTO_W-1:0] protocol;
    } t_result;

endpackage

>>> rtl/core/lld_parser.sv
// ----------------------------------------------------------------------------
// lld_parser - per-byte header parse stage
// Holds the per-packet parse state and updates it from one accepted byte per cycle;
// forms the result record on the byte that carries the last flag.
// ----------------------------------------------------------------------------
module lld_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [lld_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last,
    input  logic [lld_pkg::KIND_W-1:0]    i_link_kind,
    input  logic [lld_pkg::HDR_W-1:0]     i_default_hdr,
    input  logic [lld_pkg::BYTE_W-1:0]    i_ipv6_family,
    output logic                          o_res_valid,
    output lld_pkg::t_result              o_res
);

    typedef enum logic [2:0] {
        PH_LINK  = 3'd0,
        PH_VLAN  = 3'd1,
        PH_PPPOE = 3'd2,
        PH_MPLS  = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    localparam logic [lld_pkg::POS_W-1:0] POS_MAX = {lld_pkg::POS_W{1'b1}};

    // Parse state
    logic [lld_pkg::POS_W-1:0]   r_pos,      n_pos;
    logic [lld_pkg::PROTO_W-1:0] r_proto,    n_proto;
    t_phase                      r_phase,    n_phase;
    logic [lld_pkg::POS_W-1:0]   r_nstart,   n_nstart;
    logic [lld_pkg::LBL_W-1:0]   r_lcount,   n_lcount;
    lld_pkg::t_status            r_verdict,  n_verdict;
    logic                        r_stripped, n_stripped;
    logic [lld_pkg::BYTE_W-1:0]  r_held,     n_held;

    // MPLS byte positions within the current label
    logic [lld_pkg::POS_W:0]     w_pos_x;
    logic [lld_pkg::POS_W:0]     w_lbl_b2;
    logic [lld_pkg::POS_W:0]     w_lbl_b3;
    logic                        w_other_kind;

    assign w_pos_x      = {1'b0, r_pos};
    assign w_lbl_b2     = {1'b0, r_nstart} + 8'd2;
    assign w_lbl_b3     = {1'b0, r_nstart} + 8'd3;
    assign w_other_kind = (i_link_kind != lld_pkg::LK_LOOPBACK)
                       && (i_link_kind != lld_pkg::LK_ETHERNET)
                       && (i_link_kind != lld_pkg::LK_PPP);

    // Next-state and result logic
    always_comb begin
        n_pos       = r_pos;
        n_proto     = r_proto;
        n_phase     = r_phase;
        n_nstart    = r_nstart;
        n_lcount    = r_lcount;
        n_verdict   = r_verdict;
        n_stripped  = r_stripped;
        n_held      = r_held;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            unique case (r_phase)
                PH_LINK: begin
                    if (i_link_kind == lld_pkg::LK_LOOPBACK) begin
                        // little-endian address family in bytes 0..3
                        if (r_pos < 7'd4) begin
                            case (r_pos[1:0])
                                2'd0:    n_proto[7:0]   = i_data_byte;
                                2'd1:    n_proto[15:8]  = i_data_byte;
                                2'd2:    n_proto[23:16] = i_data_byte;
                                default: n_proto[31:24] = i_data_byte;
                            endcase
                        end
                        if (r_pos == 7'd3) begin
                            n_phase = PH_DONE;
                            if (n_proto == 32'd2 || n_proto == {24'd0, i_ipv6_family}
                                    || n_proto == 32'd24 || n_proto == 32'd28
                                    || n_proto == 32'd30) begin
                                n_verdict = lld_pkg::ST_OK;
                                n_nstart  = i_default_hdr;
                            end else begin
                                n_verdict = lld_pkg::ST_LOOP;
                                n_nstart  = '0;
                            end
                        end
                    end else if (i_link_kind == lld_pkg::LK_ETHERNET) begin
                        // ethertype in bytes 12..13
                        if (r_pos == 7'd12) begin
                            n_proto = {16'd0, i_data_byte, 8'd0};
                        end else if (r_pos == 7'd13) begin
                            n_proto = {r_proto[31:8], i_data_byte};
                            if (n_proto == 32'h0000_8847) begin
                                n_stripped = 1'b1;
                                n_nstart   = 7'd14;
                                n_lcount   = '0;
                                n_phase    = PH_MPLS;
                            end else if (n_proto == 32'h0000_8100) begin
                                n_stripped = 1'b1;
                                n_phase    = PH_VLAN;
                            end else if (n_proto == 32'h0000_8864) begin
                                n_stripped = 1'b1;
                                n_phase    = PH_PPPOE;
                            end else begin
                                n_verdict = lld_pkg::ST_OK;
                                n_nstart  = i_default_hdr;
                                n_phase   = PH_DONE;
                            end
                        end
                    end else if (i_link_kind == lld_pkg::LK_PPP) begin
                        // PPP protocol in bytes 2..3
                        if (r_pos == 7'd2) begin
                            n_proto = {16'd0, i_data_byte, 8'd0};
                        end else if (r_pos == 7'd3) begin
                            n_proto = {r_proto[31:8], i_data_byte};
                            if (n_proto == 32'h0000_0281) begin
                                n_stripped = 1'b1;
                                n_nstart   = 7'd4;
                                n_lcount   = '0;
                                n_phase    = PH_MPLS;
                            end else if (n_proto == 32'h0000_0021
                                    || n_proto == 32'h0000_0057) begin
                                n_verdict = lld_pkg::ST_OK;
                                n_nstart  = i_default_hdr;
                                n_phase   = PH_DONE;
                            end else begin
                                n_verdict = lld_pkg::ST_PPP;
                                n_nstart  = '0;
                                n_phase   = PH_DONE;
                            end
                        end
                    end
                end
                PH_VLAN: begin
                    // inner type check on bytes 20..21
                    if (r_pos == 7'd20) begin
                        n_held = i_data_byte;
                    end else if (r_pos == 7'd21) begin
                        n_verdict = lld_pkg::ST_OK;
                        n_phase   = PH_DONE;
                        n_nstart  = (r_held == 8'h08 && i_data_byte == 8'h00) ? 7'd22 : 7'd18;
                    end
                end
                PH_PPPOE: begin
                    // PPP protocol carried in bytes 20..21
                    if (r_pos == 7'd20) begin
                        n_held = i_data_byte;
                    end else if (r_pos == 7'd21) begin
                        n_proto = {16'd0, r_held, i_data_byte};
                        n_phase = PH_DONE;
                        if (n_proto == 32'h0000_0021 || n_proto == 32'h0000_0057) begin
                            n_verdict = lld_pkg::ST_OK;
                            n_nstart  = 7'd22;
                        end else begin
                            n_verdict = lld_pkg::ST_PPPOE;
                            n_nstart  = '0;
                        end
                    end
                end
                PH_MPLS: begin
                    // bottom-of-stack bit sits in the third byte of a label
                    if (w_pos_x == w_lbl_b2) begin
                        n_held = {7'd0, i_data_byte[0]};
                    end else if (w_pos_x == w_lbl_b3) begin
                        n_nstart = r_nstart + 7'd4;
                        if (r_held[0]) begin
                            n_verdict = lld_pkg::ST_OK;
                            n_phase   = PH_DONE;
                        end else if (({1'b0, r_lcount} + 5'd1)
                                >= 5'(lld_pkg::MAX_LABELS)) begin
                            n_verdict = lld_pkg::ST_DEEP;
                            n_nstart  = '0;
                            n_phase   = PH_DONE;
                        end else begin
                            n_lcount = r_lcount + 4'd1;
                        end
                    end
                end
                PH_DONE: begin
                    // trailing bytes are ignored
                end
                default: begin
                end
            endcase

            // saturating byte position
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 7'd1;
            end

            // packet end: settle the verdict and issue the result
            if (i_last) begin
                if (n_phase != PH_DONE) begin
                    if (n_phase == PH_LINK && w_other_kind) begin
                        n_verdict = lld_pkg::ST_OK;
                        n_nstart  = i_default_hdr;
                    end else begin
                        n_verdict = lld_pkg::ST_TRUNC;
                        n_nstart  = '0;
                    end
                end
                o_res_valid     = 1'b1;
                o_res.status    = n_verdict;
                o_res.protocol  = n_proto;
                if (n_verdict == lld_pkg::ST_OK) begin
                    o_res.offset  = n_nstart;
                    o_res.rep_hdr = n_stripped ? '0 : i_default_hdr;
                end
                n_pos      = '0;
                n_proto    = '0;
                n_phase    = PH_LINK;
                n_nstart   = '0;
                n_lcount   = '0;
                n_verdict  = lld_pkg::ST_OK;
                n_stripped = 1'b0;
                n_held     = '0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_proto    <= '0;
            r_phase    <= PH_LINK;
            r_nstart   <= '0;
            r_lcount   <= '0;
            r_verdict  <= lld_pkg::ST_OK;
            r_stripped <= 1'b0;
            r_held     <= '0;
        end else begin
            r_pos      <= n_pos;
            r_proto    <= n_proto;
            r_phase    <= n_phase;
            r_nstart   <= n_nstart;
            r_lcount   <= n_lcount;
            r_verdict  <= n_verdict;
            r_stripped <= n_stripped;
            r_held     <= n_held;
        end
    end

    // Label counter stays below the limit
    a_lcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lcount} < 5'(lld_pkg::MAX_LABELS)))
        else $error("label count reached the limit");

    // Label stack parsing implies a stripped header
    a_mpls_stripped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MPLS) |-> r_stripped)
        else $error("mpls phase without strip flag");

    // Packet end returns the parse state to the start
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0 && r_phase == PH_LINK && !r_stripped))
        else $error("parse state not cleared after packet end");

endmodule

>>> rtl/core/lld_out_reg.sv
// ----------------------------------------------------------------------------
// lld_out_reg - result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module lld_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lld_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output lld_pkg::t_result o_res
);

    logic             r_valid;
    lld_pkg::t_result r_res;

    // Load a new result, or drop the held one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // A load never overwrites a result still waiting on a stall
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !(r_valid && i_stall))
        else $error("result overwritten while stalled");

    // Rejected verdicts carry no offset and no header size
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status != lld_pkg::ST_OK)
            |-> (r_res.offset == '0 && r_res.rep_hdr == '0))
        else $error("rejected result with nonzero offset");

    // A load always presents a result next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

endmodule

>>> rtl/core/link_layer_decapsulation_parser.sv
// ----------------------------------------------------------------------------
// link_layer_decapsulation_parser - top level
// Byte-wide parser of loopback, ethernet (VLAN, PPPoE, MPLS) and PPP link
// headers; one verdict per packet on the byte that carries the last flag.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------------
//   in       | input     | i_in_valid / o_in_stall      | i_data_byte, i_last
//   out      | output    | o_out_valid / i_out_stall    | o_status, o_network_offset,
//            |           |                              | o_reported_header_size,
//            |           |                              | o_link_protocol
//   cfg      | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One byte is taken each cycle; the parse state updates in the same cycle and
// the result sits in the output register in the cycle after the last byte.
// The input is stalled only while a result waits in the output register and
// the output side is stalled. Configuration writes are taken every cycle.
// Synchronous reset clears the parse state and loads register defaults.
// ----------------------------------------------------------------------------
module link_layer_decapsulation_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lld_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_last,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [lld_pkg::POS_W-1:0]     o_network_offset,
    output logic [lld_pkg::HDR_W-1:0]     o_reported_header_size,
    output logic [lld_pkg::PROTO_W-1:0]   o_link_protocol,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lld_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [lld_pkg::BYTE_W-1:0]    i_cfg_data
);

    logic [lld_pkg::KIND_W-1:0] r_link_kind;
    logic [lld_pkg::HDR_W-1:0]  r_default_hdr;
    logic [lld_pkg::BYTE_W-1:0] r_ipv6_family;

    logic             w_accept;
    logic             w_res_valid;
    lld_pkg::t_result w_res;
    lld_pkg::t_result w_out_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind   <= lld_pkg::RST_LINK_KIND;
            r_default_hdr <= lld_pkg::RST_DEFAULT_HDR;
            r_ipv6_family <= lld_pkg::RST_IPV6_FAMILY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lld_pkg::REG_LINK_KIND:   r_link_kind   <= i_cfg_data[lld_pkg::KIND_W-1:0];
                lld_pkg::REG_DEFAULT_HDR: r_default_hdr <= i_cfg_data[lld_pkg::HDR_W-1:0];
                lld_pkg::REG_IPV6_FAMILY: r_ipv6_family <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input transfer handshake
    assign o_in_stall = o_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    lld_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_link_kind   (r_link_kind),
        .i_default_hdr (r_default_hdr),
        .i_ipv6_family (r_ipv6_family),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    lld_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (w_out_res)
    );

    // Result fields
    assign o_status               = w_out_res.status;
    assign o_network_offset       = w_out_res.offset;
    assign o_reported_header_size = w_out_res.rep_hdr;
    assign o_link_protocol        = w_out_res.protocol;

endmodule
